// File: sv/lrsr_pkg.sv
// ----------------------------------------------------------------------------
// lrsr_pkg: shared types and codes for the LR shift-reduce parse engine
// Entry kinds, result status codes, operations and beat layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package lrsr_pkg;

  localparam int SymW     = 3;
  localparam int StateW   = 3;
  localparam int KindW    = 3;
  localparam int TargetW  = 3;
  localparam int OpW      = 2;
  localparam int StatusW  = 3;
  localparam int CountW   = 5;
  localparam int LastW    = 2;
  localparam int InDataW  = 24;
  localparam int OutDataW = 16;

  typedef enum logic [OpW-1:0] {
    OP_ENTRY = 2'd0,
    OP_RULE  = 2'd1,
    OP_PARSE = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_EMPTY  = 3'd0,
    KIND_SHIFT  = 3'd1,
    KIND_REDUCE = 3'd2,
    KIND_GOTO   = 3'd3,
    KIND_ACCEPT = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_SHIFTED   = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_LOADED    = 3'd3,
    ST_DISCARDED = 3'd4
  } status_e;

  // input beat, lowest field in the lowest bits
  typedef struct packed {
    logic               pad;
    logic [SymW-1:0]    input_symbol;
    logic [2:0]         rule_length;
    logic [SymW-1:0]    rule_head;
    logic [1:0]         rule_index;
    logic [TargetW-1:0] entry_target;
    logic [KindW-1:0]   entry_kind;
    logic [SymW-1:0]    entry_symbol;
    logic [StateW-1:0]  entry_state;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]        pad;
    logic [LastW-1:0]  last_rule;
    logic [CountW-1:0] reduction_count;
    logic [StateW-1:0] top_state;
  } out_beat_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [TargetW-1:0] target;
  } act_entry_t;

  typedef struct packed {
    logic [SymW-1:0] head;
    logic [2:0]      len;
  } rule_entry_t;

  localparam int ActEntryW  = $bits(act_entry_t);
  localparam int RuleEntryW = $bits(rule_entry_t);

endpackage

`default_nettype wire

// File: sv/lrsr_ram.sv
// ----------------------------------------------------------------------------
// lrsr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/lr_shift_reduce_parse_engine_unit.sv
// ----------------------------------------------------------------------------
// lr_shift_reduce_parse_engine_unit: table-driven LR shift-reduce recognizer
// Loadable action/goto and rule tables, state stack in RAM, small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser is the operation (write table
//   entry, write rule, parse one symbol), tdata the entry, rule and symbol
//   fields. m_axis returns exactly one result beat per command: tuser is the
//   status, tdata the top state, reduction count and last rule.
//   cfg_we_i/cfg_wdata_i set the end-marker symbol; write only while idle.
// Timing:
//   Table writes, rule writes, discarded and out-of-range symbols finish in
//   the accept cycle. A parsed symbol reads its action entry; each
//   reduction then walks action read, rule read, stack read and goto read
//   in turn. The result is registered in the output register in the cycle
//   after the last step.
// Reset:
//   The stack holds the start state 0 and draining is off. The action table
//   is then swept to empty, one entry per cycle (all NUM_STATES*NUM_SYMBOLS
//   entries), with s_axis_tready low. Rules are undefined until written.
// Stall:
//   A result waits in the output register; a new command is taken in the
//   cycle the pending result is taken, otherwise s_axis_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_shift_reduce_parse_engine_unit #(
  parameter int NUM_STATES     = 8,
  parameter int NUM_SYMBOLS    = 8,
  parameter int NUM_RULES      = 4,
  parameter int STACK_DEPTH    = 64,
  parameter int MAX_REDUCTIONS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lrsr_pkg::SymW-1:0]     cfg_wdata_i,   // end_symbol
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_state, entry_symbol, entry_kind, entry_target, rule_index,
  // rule_head, rule_length, input_symbol, zero pad
  input  wire logic [lrsr_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic [lrsr_pkg::OpW-1:0]      s_axis_tuser,  // operation
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // top_state, reduction_count, last_rule, zero pad
  output logic [lrsr_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic [lrsr_pkg::StatusW-1:0]       m_axis_tuser   // status
);

  localparam int ActDepth = NUM_STATES * NUM_SYMBOLS;
  localparam int AW  = $clog2(ActDepth);
  localparam int RW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(MAX_REDUCTIONS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACT,
    S_RULE,
    S_BELOW,
    S_GOTO
  } seq_e;

  function automatic logic [AW-1:0] act_addr(input logic [lrsr_pkg::StateW-1:0] st,
                                             input logic [lrsr_pkg::SymW-1:0] sy);
    logic [31:0] full;
    full = 32'(st) * NUM_SYMBOLS + 32'(sy);
    return full[AW-1:0];
  endfunction

  seq_e                              state_q, state_d;
  logic [AW-1:0]                     clr_q, clr_d;
  logic [LW-1:0]                     level_q, level_d;
  logic [lrsr_pkg::StateW-1:0]       top_q, top_d;
  logic                              draining_q, draining_d;
  logic [lrsr_pkg::SymW-1:0]         sym_q, sym_d, end_q;
  logic [lrsr_pkg::SymW-1:0]         head_q, head_d;
  logic [lrsr_pkg::TargetW-1:0]      cand_q, cand_d, rule_q, rule_d;
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic [CW+4:0]                     cnt_ext;
  logic                              out_valid_q, out_valid_d;
  lrsr_pkg::status_e                 out_status_q, out_status_d;
  lrsr_pkg::out_beat_t               out_beat_q, out_beat_d;

  lrsr_pkg::in_beat_t                in_beat;
  lrsr_pkg::op_e                     in_op;
  logic                              accept;
  logic                              is_end;
  logic [lrsr_pkg::SymW-1:0]         cur_sym;
  logic                              fin;
  lrsr_pkg::status_e                 fin_st;
  logic [lrsr_pkg::StateW-1:0]       below;
  logic [LW-1:0]                     lvl_pop, lvl_below;

  logic                              act_we;
  logic [AW-1:0]                     act_waddr, act_raddr;
  lrsr_pkg::act_entry_t              act_wdata, act_rd;
  logic [lrsr_pkg::ActEntryW-1:0]    act_rdata;
  logic                              rule_we;
  logic [RW-1:0]                     rule_waddr, rule_raddr;
  lrsr_pkg::rule_entry_t             rule_wdata, rule_rd;
  logic [lrsr_pkg::RuleEntryW-1:0]   rule_rdata;
  logic                              stk_we;
  logic [SAW-1:0]                    stk_waddr, stk_raddr;
  logic [lrsr_pkg::StateW-1:0]       stk_wdata, stk_rdata;

  assign in_beat = lrsr_pkg::in_beat_t'(s_axis_tdata);
  assign in_op   = lrsr_pkg::op_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cur_sym = (state_q == S_IDLE) ? in_beat.input_symbol : sym_q;
  assign is_end  = (cur_sym == end_q);

  assign act_rd    = lrsr_pkg::act_entry_t'(act_rdata);
  assign rule_rd   = lrsr_pkg::rule_entry_t'(rule_rdata);
  assign lvl_pop   = level_q - LW'(rule_rd.len);
  assign lvl_below = lvl_pop - LW'(1);
  // bottom of the stack is always the start state
  assign below     = (level_q == LW'(1)) ? '0 : stk_rdata;

  assign rule_waddr = RW'(32'(in_beat.rule_index));
  assign rule_wdata = '{head: in_beat.rule_head, len: in_beat.rule_length};

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    level_d      = level_q;
    top_d        = top_q;
    draining_d   = draining_q;
    sym_d        = sym_q;
    head_d       = head_q;
    cand_d       = cand_q;
    rule_d       = rule_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_beat_d   = out_beat_q;
    act_we       = 1'b0;
    act_waddr    = act_addr(in_beat.entry_state, in_beat.entry_symbol);
    act_wdata    = '{kind: in_beat.entry_kind, target: in_beat.entry_target};
    act_raddr    = act_addr(top_q, sym_q);
    rule_we      = 1'b0;
    rule_raddr   = RW'(32'(act_rd.target));
    stk_we       = 1'b0;
    stk_waddr    = level_q[SAW-1:0];
    stk_wdata    = act_rd.target;
    stk_raddr    = lvl_below[SAW-1:0];
    fin          = 1'b0;
    fin_st       = lrsr_pkg::ST_LOADED;

    case (state_q)
      S_CLEAR: begin
        act_we    = 1'b1;
        act_waddr = clr_q;
        act_wdata = '0;
        if (clr_q == AW'(ActDepth - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          rule_d = '0;
          sym_d = in_beat.input_symbol;
          case (in_op)
            lrsr_pkg::OP_ENTRY: begin
              act_we = (32'(in_beat.entry_state) < NUM_STATES) &&
                       (32'(in_beat.entry_symbol) < NUM_SYMBOLS);
              fin = 1'b1;
            end
            lrsr_pkg::OP_RULE: begin
              rule_we = 32'(in_beat.rule_index) < NUM_RULES;
              fin = 1'b1;
            end
            lrsr_pkg::OP_PARSE: begin
              if (draining_q) begin
                fin = 1'b1;
                fin_st = lrsr_pkg::ST_DISCARDED;
              end else if (32'(in_beat.input_symbol) >= NUM_SYMBOLS) begin
                fin = 1'b1;
                fin_st = lrsr_pkg::ST_REJECTED;
              end else begin
                act_raddr = act_addr(top_q, in_beat.input_symbol);
                state_d = S_ACT;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_ACT: begin
        case (lrsr_pkg::kind_e'(act_rd.kind))
          lrsr_pkg::KIND_SHIFT: begin
            fin = 1'b1;
            if (32'(act_rd.target) >= NUM_STATES || 32'(level_q) >= STACK_DEPTH) begin
              fin_st = lrsr_pkg::ST_REJECTED;
            end else begin
              fin_st  = lrsr_pkg::ST_SHIFTED;
              stk_we  = 1'b1;
              level_d = level_q + LW'(1);
              top_d   = act_rd.target;
            end
          end
          lrsr_pkg::KIND_ACCEPT: begin
            fin = 1'b1;
            fin_st = lrsr_pkg::ST_ACCEPTED;
          end
          lrsr_pkg::KIND_REDUCE: begin
            if (cnt_q >= CW'(MAX_REDUCTIONS) || 32'(act_rd.target) >= NUM_RULES) begin
              fin = 1'b1;
              fin_st = lrsr_pkg::ST_REJECTED;
            end else begin
              cand_d = act_rd.target;
              state_d = S_RULE;
            end
          end
          default: begin
            fin = 1'b1;
            fin_st = lrsr_pkg::ST_REJECTED;
          end
        endcase
      end
      S_RULE: begin
        if (32'(rule_rd.head) >= NUM_SYMBOLS || 32'(rule_rd.len) >= 32'(level_q)) begin
          fin = 1'b1;
          fin_st = lrsr_pkg::ST_REJECTED;
        end else begin
          level_d = lvl_pop;
          cnt_d   = cnt_q + CW'(1);
          rule_d  = cand_q;
          head_d  = rule_rd.head;
          state_d = S_BELOW;
        end
      end
      S_BELOW: begin
        top_d     = below;
        act_raddr = act_addr(below, head_q);
        state_d   = S_GOTO;
      end
      S_GOTO: begin
        if (lrsr_pkg::kind_e'(act_rd.kind) != lrsr_pkg::KIND_GOTO ||
            32'(act_rd.target) >= NUM_STATES) begin
          fin = 1'b1;
          fin_st = lrsr_pkg::ST_REJECTED;
        end else begin
          stk_we    = 1'b1;
          level_d   = level_q + LW'(1);
          top_d     = act_rd.target;
          act_raddr = act_addr(act_rd.target, sym_q);
          state_d   = S_ACT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
      if (fin_st == lrsr_pkg::ST_DISCARDED) begin
        if (is_end) begin
          draining_d = 1'b0;
          level_d    = LW'(1);
          top_d      = '0;
        end
      end else if (fin_st != lrsr_pkg::ST_LOADED) begin
        if (fin_st == lrsr_pkg::ST_ACCEPTED || is_end) begin
          level_d = LW'(1);
          top_d   = '0;
        end else if (fin_st == lrsr_pkg::ST_REJECTED) begin
          draining_d = 1'b1;
        end
      end
      out_valid_d  = 1'b1;
      out_status_d = fin_st;
      out_beat_d.pad             = '0;
      out_beat_d.top_state       = top_d;
      out_beat_d.reduction_count = cnt_ext[lrsr_pkg::CountW-1:0];
      out_beat_d.last_rule       = rule_d[lrsr_pkg::LastW-1:0];
    end
  end

  assign cnt_ext = {5'b0, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      level_q     <= LW'(1);
      top_q       <= '0;
      draining_q  <= 1'b0;
      end_q       <= lrsr_pkg::SymW'(2);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      level_q     <= level_d;
      top_q       <= top_d;
      draining_q  <= draining_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        end_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    head_q       <= head_d;
    cand_q       <= cand_d;
    rule_q       <= rule_d;
    cnt_q        <= cnt_d;
    out_status_q <= out_status_d;
    out_beat_q   <= out_beat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = out_beat_q;

  lrsr_ram #(
    .Width(lrsr_pkg::ActEntryW),
    .Depth(ActDepth)
  ) u_act_ram (
    .clk_i  (clk_i),
    .we_i   (act_we),
    .waddr_i(act_waddr),
    .wdata_i(act_wdata),
    .raddr_i(act_raddr),
    .rdata_o(act_rdata)
  );

  lrsr_ram #(
    .Width(lrsr_pkg::RuleEntryW),
    .Depth(NUM_RULES)
  ) u_rule_ram (
    .clk_i  (clk_i),
    .we_i   (rule_we),
    .waddr_i(rule_waddr),
    .wdata_i(rule_wdata),
    .raddr_i(rule_raddr),
    .rdata_o(rule_rdata)
  );

  lrsr_ram #(
    .Width(lrsr_pkg::StateW),
    .Depth(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // only the start state sits alone on the stack
  a_bottom_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && level_q == LW'(1)) |-> (top_q == '0))
    else $error("single-entry stack with nonzero top state");

  a_drain_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && draining_q && in_op == lrsr_pkg::OP_PARSE) |=>
      (m_axis_tvalid && m_axis_tuser == lrsr_pkg::ST_DISCARDED))
    else $error("symbol while draining not discarded");

  a_load_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op != lrsr_pkg::OP_PARSE) |=>
      (m_axis_tvalid && m_axis_tuser == lrsr_pkg::ST_LOADED &&
       m_axis_tdata[lrsr_pkg::StateW +: lrsr_pkg::CountW] == '0))
    else $error("load beat without loaded status");

endmodule

`default_nettype wire
